>>> hw/rtl/rv32im_execute_stage_assert.svh
// Assertion macros for the RV32IM execute stage checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef RV32IM_EXECUTE_STAGE_ASSERT_SVH
`define RV32IM_EXECUTE_STAGE_ASSERT_SVH

// Same-cycle implication, off during reset
`define RVX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define RVX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rvx_pkg.sv
// Shared types and constants of the RV32IM execute stage.
// No dependencies.
package rvx_pkg;

    localparam int unsigned DIV_STEPS = 32;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic [31:0] insn;
        logic [31:0] pc;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
        logic [31:0] load_data;
    } req_t;

    typedef struct packed {
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic [31:0] mem_addr;
        logic        mem_read;
        logic        mem_write;
        logic [1:0]  mem_size;
        logic [31:0] store_data;
        logic        illegal;
    } rsp_t;

    // Result plus the late-result selection that rides down the pipe
    typedef struct packed {
        rsp_t rsp;
        logic is_mul;
        logic mul_hi;
        logic a_signed;
        logic b_signed;
        logic is_div;
        logic div_rem;
        logic neg_out;
    } info_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
    } div_row_t;

    // One restoring-division step: shift in one dividend bit, try subtract
    function automatic div_row_t div_step(input div_row_t row);
        logic [32:0] shifted;
        logic [32:0] diff;
        div_row_t    nxt;
        shifted = {row.rem, row.quo[31]};
        diff    = shifted - {1'b0, row.dvs};
        nxt.dvs = row.dvs;
        if (!diff[32])
        begin
            nxt.rem = diff[31:0];
            nxt.quo = {row.quo[30:0], 1'b1};
        end
        else
        begin
            nxt.rem = shifted[31:0];
            nxt.quo = {row.quo[30:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

>>> hw/rtl/rvx_decode.sv
// Combinational decode and execute of one RV32IM instruction.
// Depends on rvx_pkg; multiply and divide operands are prepared for later stages.
module rvx_decode
    import rvx_pkg::*;
(
    input  req_t        req,
    output info_t       info,
    output logic [31:0] mul_a,
    output logic [31:0] mul_b,
    output logic [31:0] dividend,
    output logic [31:0] divisor
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] insn;
    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] immu;
    logic [4:0]  shamt;
    logic [4:0]  rshamt;
    logic [31:0] pc4;
    logic        bad;
    logic        wr;
    logic        take;
    logic        sgn;
    rsp_t        r;

    assign a      = req.rs1_value;
    assign b      = req.rs2_value;
    assign insn   = req.insn;
    assign opcode = insn[6:0];
    assign rd     = insn[11:7];
    assign f3     = insn[14:12];
    assign f7     = insn[31:25];
    assign immi   = {{20{insn[31]}}, insn[31:20]};
    assign imms   = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    assign immb   = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    assign immj   = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    assign immu   = {insn[31:12], 12'h000};
    assign shamt  = insn[24:20];
    assign rshamt = b[4:0];
    assign pc4    = req.pc + 32'd4;

    // Operands for the multiplier, taken raw
    assign mul_a = a;
    assign mul_b = b;

    // Signed divide works on magnitudes; funct3 bit 0 marks unsigned
    assign sgn      = ~f3[0];
    assign dividend = (sgn && a[31]) ? (32'd0 - a) : a;
    assign divisor  = (sgn && b[31]) ? (32'd0 - b) : b;

    // Decode and execute
    always_comb
    begin
        r            = '0;
        r.rd_index   = rd;
        r.next_pc    = pc4;
        bad          = 1'b0;
        wr           = 1'b0;
        take         = 1'b0;
        info         = '0;
        unique case (opcode)
            OPC_LUI:
            begin
                r.rd_value = immu;
                wr         = 1'b1;
            end
            OPC_AUIPC:
            begin
                r.rd_value = req.pc + immu;
                wr         = 1'b1;
            end
            OPC_JAL:
            begin
                r.rd_value = pc4;
                r.next_pc  = req.pc + immj;
                wr         = 1'b1;
            end
            OPC_JALR:
            begin
                if (f3 != 3'd0)
                    bad = 1'b1;
                r.rd_value = pc4;
                r.next_pc  = (a + immi) & ~32'd1;
                wr         = 1'b1;
            end
            OPC_BRANCH:
            begin
                unique case (f3[2:1])
                    2'd0: take = (a == b);
                    2'd2: take = ($signed(a) < $signed(b));
                    2'd3: take = (a < b);
                    default: bad = 1'b1;
                endcase
                if (take ^ f3[0])
                    r.next_pc = req.pc + immb;
            end
            OPC_LOAD:
            begin
                r.mem_addr = a + immi;
                r.mem_read = 1'b1;
                wr         = 1'b1;
                unique case (f3)
                    F3_LB:
                    begin
                        r.rd_value = {{24{req.load_data[7]}}, req.load_data[7:0]};
                        r.mem_size = SIZE_BYTE;
                    end
                    F3_LH:
                    begin
                        r.rd_value = {{16{req.load_data[15]}}, req.load_data[15:0]};
                        r.mem_size = SIZE_HALF;
                    end
                    F3_LW:
                    begin
                        r.rd_value = req.load_data;
                        r.mem_size = SIZE_WORD;
                    end
                    F3_LBU:
                    begin
                        r.rd_value = {24'd0, req.load_data[7:0]};
                        r.mem_size = SIZE_BYTE;
                    end
                    F3_LHU:
                    begin
                        r.rd_value = {16'd0, req.load_data[15:0]};
                        r.mem_size = SIZE_HALF;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_STORE:
            begin
                if (f3 > 3'd2)
                    bad = 1'b1;
                r.mem_addr   = a + imms;
                r.mem_write  = 1'b1;
                r.mem_size   = f3[1:0];
                r.store_data = b;
            end
            OPC_OPIMM:
            begin
                wr = 1'b1;
                unique case (f3)
                    F3_ADD:  r.rd_value = a + immi;
                    F3_SLL:
                    begin
                        if (f7 != F7_BASE)
                            bad = 1'b1;
                        r.rd_value = a << shamt;
                    end
                    F3_SLT:  r.rd_value = {31'd0, $signed(a) < $signed(immi)};
                    F3_SLTU: r.rd_value = {31'd0, a < immi};
                    F3_XOR:  r.rd_value = a ^ immi;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            r.rd_value = a >> shamt;
                        else if (f7 == F7_ALT)
                            r.rd_value = 32'($signed(a) >>> shamt);
                        else
                            bad = 1'b1;
                    end
                    F3_OR:   r.rd_value = a | immi;
                    F3_AND:  r.rd_value = a & immi;
                    default: r.rd_value = '0;
                endcase
            end
            OPC_OP:
            begin
                wr = 1'b1;
                if (f7 == F7_MULDIV)
                begin
                    if (!f3[2])
                    begin
                        info.is_mul   = 1'b1;
                        info.mul_hi   = (f3 != 3'd0);
                        info.a_signed = (f3 == 3'd1) || (f3 == 3'd2);
                        info.b_signed = (f3 == 3'd1);
                    end
                    else
                    begin
                        info.is_div  = 1'b1;
                        info.div_rem = f3[1];
                        if (f3[1])
                            info.neg_out = sgn && a[31];
                        else
                            info.neg_out = sgn && (a[31] ^ b[31]) && (b != 32'd0);
                    end
                end
                else if (f7 == F7_BASE)
                begin
                    unique case (f3)
                        F3_ADD:  r.rd_value = a + b;
                        F3_SLL:  r.rd_value = a << rshamt;
                        F3_SLT:  r.rd_value = {31'd0, $signed(a) < $signed(b)};
                        F3_SLTU: r.rd_value = {31'd0, a < b};
                        F3_XOR:  r.rd_value = a ^ b;
                        F3_SR:   r.rd_value = a >> rshamt;
                        F3_OR:   r.rd_value = a | b;
                        F3_AND:  r.rd_value = a & b;
                        default: r.rd_value = '0;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    r.rd_value = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    r.rd_value = 32'($signed(a) >>> rshamt);
                else
                    bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase

        // Drop everything for an illegal instruction, hold the pc
        if (bad)
        begin
            r          = '0;
            r.rd_index = rd;
            r.next_pc  = req.pc;
            r.illegal  = 1'b1;
            wr         = 1'b0;
            info       = '0;
        end
        r.rd_write = wr && (rd != 5'd0);
        if (!r.rd_write)
            r.rd_value = '0;
        info.rsp = r;
    end

endmodule

>>> hw/rtl/rvx_divider.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on rvx_pkg for the row type and the step function.
module rvx_divider
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    div_row_t row_reg [0:DIV_STEPS];

    // Load the first row: empty remainder, dividend shifts out of quo
    always_ff @(posedge clk)
    begin
        if (adv)
            row_reg[0] <= '{rem: '0, quo: dividend, dvs: divisor};
    end

    // One step per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        div_row_t row_next;
        assign row_next = div_step(row_reg[k]);
        always_ff @(posedge clk)
        begin
            if (adv)
                row_reg[k+1] <= row_next;
        end
    end

    assign quotient  = row_reg[DIV_STEPS].quo;
    assign remainder = row_reg[DIV_STEPS].rem;

endmodule

>>> hw/rtl/rv32im_execute_stage.sv
// Top level of the RV32IM execute stage: input register, decode, multiply and
// divide pipelines, output register. Depends on rvx_pkg, rvx_decode, rvx_divider.
//
//   channel | signals                    | beat
//   --------+----------------------------+-----------------------------------
//   req     | req_valid, req_ready, req  | insn, pc, rs1/rs2 values, load data
//   rsp     | rsp_valid, rsp_ready, rsp  | register write, next pc, memory req
//
// One beat enters per cycle while rsp is not stalled; each beat passes through
// the input register, the 32 divider stages and the output register.
// Reset clears only the valid bits. A stall on rsp freezes the whole pipe;
// req_ready is high whenever the output register is empty or being taken.
module rv32im_execute_stage
    import rvx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic        adv;
    logic        in_vld_reg;
    req_t        in_reg;
    info_t       dec_info;
    logic [31:0] dec_mul_a;
    logic [31:0] dec_mul_b;
    logic [31:0] dec_dividend;
    logic [31:0] dec_divisor;
    logic [31:0] quotient;
    logic [31:0] remainder;

    info_t       info_reg  [0:DIV_STEPS];
    logic        vld_reg   [0:DIV_STEPS];
    info_t       info_next [1:DIV_STEPS];

    logic [31:0] mula_reg;
    logic [31:0] mulb_reg;
    logic [63:0] prod_reg;
    logic [31:0] pa_reg;
    logic [31:0] pb_reg;
    logic [31:0] mul_hi;
    logic [31:0] mul_val;
    logic [31:0] div_mag;
    logic [31:0] div_val;

    logic        rsp_vld_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;

    // Whole pipe advances unless the output beat is stuck
    assign adv       = !rsp_vld_reg || rsp_ready;
    assign req_ready = adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (adv)
            in_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= req;
    end

    rvx_decode u_decode (
        .req      (in_reg),
        .info     (dec_info),
        .mul_a    (dec_mul_a),
        .mul_b    (dec_mul_b),
        .dividend (dec_dividend),
        .divisor  (dec_divisor)
    );

    rvx_divider u_divider (
        .clk       (clk),
        .adv       (adv),
        .dividend  (dec_dividend),
        .divisor   (dec_divisor),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Multiply: raw product one stage, sign correction the next
    assign mul_hi = prod_reg[63:32]
                  - ((info_reg[1].a_signed && pa_reg[31]) ? pb_reg : 32'd0)
                  - ((info_reg[1].b_signed && pb_reg[31]) ? pa_reg : 32'd0);
    assign mul_val = info_reg[1].mul_hi ? mul_hi : prod_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mula_reg <= dec_mul_a;
            mulb_reg <= dec_mul_b;
            prod_reg <= mula_reg * mulb_reg;
            pa_reg   <= mula_reg;
            pb_reg   <= mulb_reg;
        end
    end

    // Carry the decoded result; drop the product in at stage two
    always_comb
    begin
        for (int k = 1; k <= DIV_STEPS; k++)
            info_next[k] = info_reg[k-1];
        if (info_reg[1].is_mul && info_reg[1].rsp.rd_write)
            info_next[2].rsp.rd_value = mul_val;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0] <= dec_info;
            for (int k = 1; k <= DIV_STEPS; k++)
                info_reg[k] <= info_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Divide result: pick quotient or remainder, restore the sign
    assign div_mag = info_reg[DIV_STEPS].div_rem ? remainder : quotient;
    assign div_val = info_reg[DIV_STEPS].neg_out ? (32'd0 - div_mag) : div_mag;

    always_comb
    begin
        rsp_next = info_reg[DIV_STEPS].rsp;
        if (info_reg[DIV_STEPS].is_div && info_reg[DIV_STEPS].rsp.rd_write)
            rsp_next.rd_value = div_val;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (adv)
            rsp_vld_reg <= vld_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/rvx_checker.sv
// Port-level checks of the RV32IM execute stage, bound to the top level.
// Depends on rvx_pkg and rv32im_execute_stage_assert.svh.
`include "rv32im_execute_stage_assert.svh"

module rvx_checker
    import rvx_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // Hold a waiting request beat
    `RVX_ASSERT_NXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "req beat changed while waiting")

    // Hold a stalled result beat
    `RVX_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat changed while stalled")

    // Accept whenever the output is empty
    `RVX_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready, "req stalled with empty output")

    // Illegal beats carry no write and no memory access
    `RVX_ASSERT_IMP(a_illegal_quiet, rsp_valid && rsp.illegal, !rsp.rd_write && !rsp.mem_read && !rsp.mem_write, "illegal beat has side effects")

    // Never a write to x0, never load and store at once
    `RVX_ASSERT_IMP(a_rd_mem, rsp_valid, !(rsp.rd_write && rsp.rd_index == 5'd0) && !(rsp.mem_read && rsp.mem_write), "bad write or memory request")

endmodule

bind rv32im_execute_stage rvx_checker u_rvx_checker (.*);

>>> tb/rv32im_execute_stage_tb.sv
// Self-checking testbench for the RV32IM execute stage.
// Depends on rvx_pkg and rv32im_execute_stage; predicts results in-line or takes hand-written ones.
module rv32im_execute_stage_tb;
    import rvx_pkg::*;

    localparam int N_RANDOM   = 1200;
    localparam int WDOG_LIMIT = 20000;
    localparam int LATENCY    = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    rsp_t   expected_q[$];
    int     err_cnt = 0;
    bit     drive_done;
    bit     hold_off;
    int     idle_cycles;
    int     rx_wait;

    // directed stimulus row; has_exp marks a hand-written expected result
    typedef struct {
        req_t beat;
        bit   has_exp;
        rsp_t exp;
    } dir_row_t;

    dir_row_t dir_rows[$];

    rv32im_execute_stage i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'h1 << (bits - 1);
        v = (bits >= 32) ? v : (v & ((32'h1 << bits) - 1));
        return (v ^ m) - m;
    endfunction

    function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [31:0] b,
                                           input bit a_s, input bit b_s);
        logic signed [65:0] aa;
        logic signed [65:0] bb;
        logic signed [65:0] p;
        aa = a_s ? {{34{a[31]}}, a} : {34'b0, a};
        bb = b_s ? {{34{b[31]}}, b} : {34'b0, b};
        p  = aa * bb;
        return p[63:32];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] a);
        return a[31] ? -a : a;
    endfunction

    // compute the architectural result of one instruction
    function automatic rsp_t execute_insn(input req_t r);
        rsp_t        o;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] immi;
        logic [31:0] imm;
        logic [31:0] val;
        logic [4:0]  sh;
        bit          wr;
        bit          bad;
        bit          c;
        a    = r.rs1_value;
        b    = r.rs2_value;
        opc  = r.insn[6:0];
        f3   = r.insn[14:12];
        f7   = r.insn[31:25];
        immi = sx({20'b0, r.insn[31:20]}, 12);
        sh   = r.insn[24:20];
        o    = '0;
        o.rd_index = r.insn[11:7];
        o.next_pc  = r.pc + 4;
        val = 0;
        wr  = 0;
        bad = 0;
        case (opc)
            OPC_LUI:
            begin
                val = r.insn & 32'hfffff000;
                wr  = 1;
            end
            OPC_AUIPC:
            begin
                val = r.pc + (r.insn & 32'hfffff000);
                wr  = 1;
            end
            OPC_JAL:
            begin
                imm = {11'b0, r.insn[31], r.insn[19:12], r.insn[20], r.insn[30:21], 1'b0};
                val = r.pc + 4;
                wr  = 1;
                o.next_pc = r.pc + sx(imm, 21);
            end
            OPC_JALR:
            begin
                if (f3 != 0)
                    bad = 1;
                else
                begin
                    val = r.pc + 4;
                    wr  = 1;
                    o.next_pc = (a + immi) & ~32'h1;
                end
            end
            OPC_BRANCH:
            begin
                imm = {19'b0, r.insn[31], r.insn[7], r.insn[30:25], r.insn[11:8], 1'b0};
                case (f3[2:1])
                    2'd0: c = (a == b);
                    2'd2: c = $signed(a) < $signed(b);
                    2'd3: c = a < b;
                    default: bad = 1;
                endcase
                if (!bad)
                begin
                    if (f3[0])
                        c = !c;
                    if (c)
                        o.next_pc = r.pc + sx(imm, 13);
                end
            end
            OPC_LOAD:
            begin
                o.mem_addr = a + immi;
                case (f3)
                    F3_LB:   begin val = sx(r.load_data, 8);  o.mem_size = SIZE_BYTE; end
                    F3_LH:   begin val = sx(r.load_data, 16); o.mem_size = SIZE_HALF; end
                    F3_LW:   begin val = r.load_data;         o.mem_size = SIZE_WORD; end
                    F3_LBU:  begin val = r.load_data & 32'hff;   o.mem_size = SIZE_BYTE; end
                    F3_LHU:  begin val = r.load_data & 32'hffff; o.mem_size = SIZE_HALF; end
                    default: bad = 1;
                endcase
                if (!bad)
                begin
                    wr = 1;
                    o.mem_read = 1;
                end
            end
            OPC_STORE:
            begin
                if (f3 > 2)
                    bad = 1;
                else
                begin
                    o.mem_addr   = a + sx({20'b0, f7, r.insn[11:7]}, 12);
                    o.mem_write  = 1;
                    o.mem_size   = f3[1:0];
                    o.store_data = b;
                end
            end
            OPC_OPIMM:
            begin
                case (f3)
                    F3_ADD:  val = a + immi;
                    F3_SLL:  if (f7 != F7_BASE) bad = 1; else val = a << sh;
                    F3_SLT:  val = ($signed(a) < $signed(immi)) ? 1 : 0;
                    F3_SLTU: val = (a < immi) ? 1 : 0;
                    F3_XOR:  val = a ^ immi;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            val = a >> sh;
                        else if (f7 == F7_ALT)
                            val = $signed(a) >>> sh;
                        else
                            bad = 1;
                    end
                    F3_OR:   val = a | immi;
                    default: val = a & immi;
                endcase
                wr = !bad;
            end
            OPC_OP:
            begin
                if (f7 == F7_MULDIV)
                begin
                    case (f3)
                        3'd0: val = a * b;
                        3'd1: val = mul_hi(a, b, 1, 1);
                        3'd2: val = mul_hi(a, b, 1, 0);
                        3'd3: val = mul_hi(a, b, 0, 0);
                        3'd4:
                        begin
                            if (b == 0)
                                val = 32'hffffffff;
                            else if (a == 32'h80000000 && b == 32'hffffffff)
                                val = a;
                            else
                            begin
                                val = abs32(a) / abs32(b);
                                if (a[31] ^ b[31])
                                    val = -val;
                            end
                        end
                        3'd5: val = (b == 0) ? 32'hffffffff : a / b;
                        3'd6:
                        begin
                            if (b == 0)
                                val = a;
                            else if (a == 32'h80000000 && b == 32'hffffffff)
                                val = 0;
                            else
                            begin
                                val = abs32(a) % abs32(b);
                                if (a[31])
                                    val = -val;
                            end
                        end
                        default: val = (b == 0) ? a : a % b;
                    endcase
                end
                else if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[4:0];
                        F3_SLT:  val = ($signed(a) < $signed(b)) ? 1 : 0;
                        F3_SLTU: val = (a < b) ? 1 : 0;
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[4:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    val = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    val = $signed(a) >>> b[4:0];
                else
                    bad = 1;
                wr = !bad;
            end
            default: bad = 1;
        endcase
        if (bad)
        begin
            o = '0;
            o.rd_index = r.insn[11:7];
            o.next_pc  = r.pc;
            o.illegal  = 1;
            wr = 0;
        end
        if (o.rd_index == 0)
            wr = 0;
        o.rd_write = wr;
        o.rd_value = wr ? val : 32'h0;
        return o;
    endfunction

    function automatic logic [31:0] rvec();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return 32'h7fffffff;
            4: return $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // mostly legal encodings with random fields, some raw noise
    function automatic req_t rand_beat();
        req_t       r;
        logic [6:0] opcs[9];
        logic [6:0] f7;
        opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH,
                 OPC_LOAD, OPC_STORE, OPC_OPIMM, OPC_OP};
        r.insn      = $urandom;
        r.pc        = $urandom;
        r.rs1_value = rvec();
        r.rs2_value = rvec();
        r.load_data = $urandom;
        if ($urandom_range(0, 9) != 0)
        begin
            r.insn[6:0] = opcs[$urandom_range(0, 8)];
            if (r.insn[6:0] == OPC_OP || (r.insn[6:0] == OPC_OPIMM && r.insn[13:12] == 2'b01))
            begin
                case ($urandom_range(0, 7))
                    0, 1: f7 = F7_BASE;
                    2, 3, 4: f7 = F7_MULDIV;
                    5, 6: f7 = F7_ALT;
                    default: f7 = 7'($urandom);
                endcase
                r.insn[31:25] = f7;
            end
        end
        return r;
    endfunction

    function automatic req_t mk(input logic [31:0] insn, input logic [31:0] pc,
                                input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] ld);
        req_t r;
        r.insn      = insn;
        r.pc        = pc;
        r.rs1_value = a;
        r.rs2_value = b;
        r.load_data = ld;
        return r;
    endfunction

    task automatic add_row(input req_t r, input bit has_exp, input rsp_t e);
        dir_row_t d;
        d.beat    = r;
        d.has_exp = has_exp;
        d.exp     = e;
        dir_rows.push_back(d);
    endtask

    // fill the directed table
    task automatic build_directed();
        rsp_t e;
        // illegal: SYSTEM opcode, keeps pc, reports rd
        e = '0;
        e.rd_index = 5'd3;
        e.next_pc  = 32'h00001000;
        e.illegal  = 1;
        add_row(mk(32'h00000073 | (3 << 7), 32'h1000, 32'hffffffff, 32'hffffffff, 0), 1, e);
        // illegal: opcode with low bits not 11
        e.rd_index = 5'd0;
        e.next_pc  = 32'hfffffffc;
        add_row(mk(32'h00000000, 32'hfffffffc, 0, 0, 0), 1, e);
        // LUI x31 with all-ones immediate
        e = '0;
        e.rd_index = 5'd31;
        e.rd_write = 1;
        e.rd_value = 32'hfffff000;
        e.next_pc  = 32'h00000000;
        add_row(mk(32'hfffff000 | (31 << 7) | OPC_LUI, 32'hfffffffc, 0, 0, 0), 1, e);
        // LUI to x0 writes nothing
        e = '0;
        e.next_pc = 32'h4;
        add_row(mk(32'hfffff000 | OPC_LUI, 0, 0, 0, 0), 1, e);
        // the remaining rows go through the predictor
        add_row(mk(32'h80000000 | (5 << 7) | OPC_AUIPC, 32'h80000000, 0, 0, 0), 0, e);
        add_row(mk(32'h800000ef, 32'h10, 0, 0, 0), 0, e);        // JAL backward
        add_row(mk(32'h7ffff0ef, 32'hfffffff0, 0, 0, 0), 0, e);  // JAL forward wrap
        add_row(mk(32'hfff08067 | (1 << 7), 32'h20, 32'h7, 0, 0), 0, e);  // JALR negative offset
        add_row(mk(32'h00009067 | (1 << 7), 32'h20, 32'h7, 0, 0), 0, e);  // JALR bad funct3
        add_row(mk(32'hfe000ee3, 32'h100, 5, 5, 0), 0, e);              // BEQ taken back
        add_row(mk(32'h00002063, 32'h100, 5, 5, 0), 0, e);              // branch funct3 2
        add_row(mk(32'h00004463, 32'h100, 32'h80000000, 1, 0), 0, e);   // BLT
        add_row(mk(32'h00007463, 32'h100, 32'h80000000, 1, 0), 0, e);   // BGEU
        add_row(mk(32'hfff00083 | (2 << 7), 0, 0, 0, 32'h80), 0, e);    // LB sign
        add_row(mk(32'h00005003 | (2 << 7), 0, 4, 0, 32'hffff8000), 0, e); // LHU
        add_row(mk(32'h00003003 | (2 << 7), 0, 4, 0, 32'h1), 0, e);     // load funct3 3
        add_row(mk(32'hfe002fa3, 0, 32'h1000, 32'hdeadbeef, 0), 0, e);  // SW
        add_row(mk(32'h00003023, 0, 32'h1000, 32'h1, 0), 0, e);         // store funct3 3
        add_row(mk(32'h41f0d093, 0, 32'h80000000, 0, 0), 0, e);         // SRAI 31
        add_row(mk(32'h40001093, 0, 32'h1, 0, 0), 0, e);                // SLLI bad funct7
        add_row(mk(32'h02b54533, 0, 32'h80000000, 32'hffffffff, 0), 0, e); // DIV overflow
        add_row(mk(32'h02b56533, 0, 32'h80000000, 32'hffffffff, 0), 0, e); // REM overflow
        add_row(mk(32'h02b55533, 0, 32'h1234, 0, 0), 0, e);             // DIVU by zero
        add_row(mk(32'h02b51533, 0, 32'h80000000, 32'h80000000, 0), 0, e); // MULH
        add_row(mk(32'h40b51533, 0, 1, 2, 0), 0, e);                    // OP alt f3 1
    endtask

    // drop valid only when a gap follows, so back-to-back beats keep it high
    task automatic send_beat(input req_t r);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_q.push_back(execute_insn(r));
    endtask

    // sender
    initial
    begin
        req_t r;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        drive_done = 0;
        build_directed();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].beat);
            if (dir_rows[i].has_exp)
                expected_q[$] = dir_rows[i].exp;
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = rand_beat();
            send_beat(r);
        end
        req_valid <= 1'b0;
        drive_done = 1;
    end

    // receiver hold-off; one long stretch stalls the whole pipe
    initial
    begin
        hold_off = 0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
    end

    // receiver idling: draw a random wait after each taken beat
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (hold_off)
            rsp_ready <= 1'b0;
        else if (rsp_valid && rsp_ready)
        begin
            w = $urandom_range(0, 11);
            rsp_ready <= (w == 0);
            rx_wait   <= (w == 0) ? 0 : w - 1;
        end
        else if (!rsp_ready)
        begin
            if (rx_wait == 0)
                rsp_ready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                err_cnt++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.rd_index !== e.rd_index)
                begin
                    $error("rd_index exp %0h got %0h", e.rd_index, rsp.rd_index);
                    err_cnt++;
                end
                if (rsp.rd_write !== e.rd_write)
                begin
                    $error("rd_write exp %0h got %0h", e.rd_write, rsp.rd_write);
                    err_cnt++;
                end
                if (rsp.rd_value !== e.rd_value)
                begin
                    $error("rd_value exp %0h got %0h", e.rd_value, rsp.rd_value);
                    err_cnt++;
                end
                if (rsp.next_pc !== e.next_pc)
                begin
                    $error("next_pc exp %0h got %0h", e.next_pc, rsp.next_pc);
                    err_cnt++;
                end
                if (rsp.mem_addr !== e.mem_addr)
                begin
                    $error("mem_addr exp %0h got %0h", e.mem_addr, rsp.mem_addr);
                    err_cnt++;
                end
                if (rsp.mem_read !== e.mem_read)
                begin
                    $error("mem_read exp %0h got %0h", e.mem_read, rsp.mem_read);
                    err_cnt++;
                end
                if (rsp.mem_write !== e.mem_write)
                begin
                    $error("mem_write exp %0h got %0h", e.mem_write, rsp.mem_write);
                    err_cnt++;
                end
                if (rsp.mem_size !== e.mem_size)
                begin
                    $error("mem_size exp %0h got %0h", e.mem_size, rsp.mem_size);
                    err_cnt++;
                end
                if (rsp.store_data !== e.store_data)
                begin
                    $error("store_data exp %0h got %0h", e.store_data, rsp.store_data);
                    err_cnt++;
                end
                if (rsp.illegal !== e.illegal)
                begin
                    $error("illegal exp %0h got %0h", e.illegal, rsp.illegal);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: count cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // finish once everything has drained, or on a stuck pipe
    initial
    begin
        @(posedge rst_n);
        while (!(drive_done && expected_q.size() == 0) && idle_cycles < WDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
        end
        else
        begin
            repeat (LATENCY) @(posedge clk);
            if (err_cnt == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
